>>> hdl/brbq_pkg.sv
// ----------------------------------------------------------------------------
// brbq_pkg
// Shared widths, codes and beat types of the circular byte queue.
// ----------------------------------------------------------------------------
package brbq_pkg;

    localparam int BYTE_W            = 8;
    localparam int LEN_W             = 11;
    localparam int STORE_DEPTH_DEF   = 1024;
    localparam int MAX_READ          = 64;
    localparam int CMDQ_DEPTH        = 4;
    localparam logic [LEN_W-1:0] LEN_RESET = 11'd1024;

    // request codes
    localparam logic [1:0] REQ_WRITE = 2'd0;
    localparam logic [1:0] REQ_READ  = 2'd1;
    localparam logic [1:0] REQ_CLEAR = 2'd2;
    localparam logic [1:0] REQ_QUERY = 2'd3;

    // status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_OVERFLOW = 2'd1;
    localparam logic [1:0] ST_EMPTY    = 2'd2;
    localparam logic [1:0] ST_INVALID  = 2'd3;

    typedef struct packed {
        logic [1:0]        req_type;
        logic [BYTE_W-1:0] write_byte;
        logic [LEN_W-1:0]  transfer_length;
    } req_t;

    typedef struct packed {
        logic [BYTE_W-1:0] read_byte;
        logic [1:0]        status;
        logic [LEN_W-1:0]  transfer_count;
        logic [LEN_W-1:0]  used_bytes;
        logic              is_empty;
        logic              is_full;
        logic              last;
    } rsp_t;

    // one classified command from the front end to the back end
    typedef struct packed {
        logic              is_read;
        logic              wr_en;
        logic [LEN_W-1:0]  addr;
        logic [BYTE_W-1:0] data;
        logic [1:0]        status;
        logic [LEN_W-1:0]  count;
        logic [LEN_W-1:0]  used;
        logic              is_empty;
        logic              is_full;
    } cmd_t;

endpackage

>>> hdl/brbq_front.sv
// ----------------------------------------------------------------------------
// brbq_front
// Classify requests, own pointers and used count, push commands.
// ----------------------------------------------------------------------------
module brbq_front
    import brbq_pkg::*;
#(
    parameter int STORE_DEPTH = STORE_DEPTH_DEF
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  req_t             request,
    input  logic             cfg_wr_en,
    input  logic [LEN_W-1:0] cfg_wr_data,
    input  logic             q_full,
    output logic             busy,
    output logic             push,
    output cmd_t             push_cmd,
    output logic [LEN_W-1:0] act_len
);

    logic [LEN_W-1:0] len_cfg_reg;
    logic [LEN_W-1:0] rp_reg, rp_next;
    logic [LEN_W-1:0] wp_reg, wp_next;
    logic [LEN_W-1:0] used_reg, used_next;
    logic [LEN_W-1:0] wleft_reg, wleft_next;
    logic             granted_reg, granted_next;

    assign busy = q_full;
    assign push = start && !busy;

    always_comb
    begin
        if (len_cfg_reg == '0)
        begin
            act_len = LEN_W'(1);
        end
        else if (32'(len_cfg_reg) > STORE_DEPTH)
        begin
            act_len = LEN_W'(STORE_DEPTH);
        end
        else
        begin
            act_len = len_cfg_reg;
        end
    end

    always_comb
    begin
        logic [LEN_W:0]   sum;
        logic [LEN_W:0]   wp_inc;
        logic [LEN_W:0]   rp_adv;
        logic [LEN_W-1:0] tl;
        logic [LEN_W-1:0] n_tmp;
        logic [LEN_W-1:0] n;
        logic             enq;

        tl     = request.transfer_length;
        sum    = {1'b0, used_reg} + {1'b0, tl};
        wp_inc = {1'b0, wp_reg} + (LEN_W+1)'(1);
        n_tmp  = (tl > used_reg) ? used_reg : tl;
        n      = (n_tmp > LEN_W'(MAX_READ)) ? LEN_W'(MAX_READ) : n_tmp;
        rp_adv = {1'b0, rp_reg} + {1'b0, n};
        enq    = 1'b0;

        rp_next      = rp_reg;
        wp_next      = wp_reg;
        used_next    = used_reg;
        wleft_next   = '0;
        granted_next = 1'b0;

        push_cmd         = '0;
        push_cmd.addr    = wp_reg;
        push_cmd.data    = request.write_byte;
        push_cmd.status  = ST_OK;

        case (request.req_type)
            REQ_WRITE:
            begin
                wleft_next   = wleft_reg;
                granted_next = granted_reg;
                if (wleft_reg == '0)
                begin
                    if (tl == '0)
                    begin
                        push_cmd.status = ST_INVALID;
                    end
                    else if (sum > {1'b0, act_len})
                    begin
                        push_cmd.status = ST_OVERFLOW;
                        granted_next    = 1'b0;
                        wleft_next      = tl - LEN_W'(1);
                    end
                    else
                    begin
                        granted_next   = 1'b1;
                        wleft_next     = tl - LEN_W'(1);
                        enq            = 1'b1;
                        push_cmd.count = tl;
                    end
                end
                else
                begin
                    wleft_next = wleft_reg - LEN_W'(1);
                    if (granted_reg && (used_reg < act_len))
                    begin
                        enq = 1'b1;
                    end
                    else
                    begin
                        push_cmd.status = ST_OVERFLOW;
                    end
                end
                if (wleft_next == '0)
                begin
                    granted_next = 1'b0;
                end
                if (enq)
                begin
                    push_cmd.wr_en = 1'b1;
                    wp_next   = (wp_inc >= {1'b0, act_len}) ? '0 : wp_inc[LEN_W-1:0];
                    used_next = used_reg + LEN_W'(1);
                end
            end
            REQ_READ:
            begin
                if (used_reg == '0)
                begin
                    push_cmd.status = ST_EMPTY;
                end
                else if (n != '0)
                begin
                    push_cmd.is_read = 1'b1;
                    push_cmd.addr    = rp_reg;
                    push_cmd.count   = n;
                    used_next        = used_reg - n;
                    rp_next = (rp_adv >= {1'b0, act_len}) ?
                              LEN_W'(rp_adv - {1'b0, act_len}) : rp_adv[LEN_W-1:0];
                end
            end
            REQ_CLEAR:
            begin
                rp_next   = '0;
                wp_next   = '0;
                used_next = '0;
            end
            default:
            begin
                // query: state unchanged, pending transfer ends
            end
        endcase

        push_cmd.used     = used_next;
        push_cmd.is_empty = (used_next == '0);
        push_cmd.is_full  = (used_next == act_len);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_cfg_reg <= LEN_RESET;
            rp_reg      <= '0;
            wp_reg      <= '0;
            used_reg    <= '0;
            wleft_reg   <= '0;
            granted_reg <= 1'b0;
        end
        else if (cfg_wr_en)
        begin
            len_cfg_reg <= cfg_wr_data;
            rp_reg      <= '0;
            wp_reg      <= '0;
            used_reg    <= '0;
            wleft_reg   <= '0;
            granted_reg <= 1'b0;
        end
        else if (push)
        begin
            rp_reg      <= rp_next;
            wp_reg      <= wp_next;
            used_reg    <= used_next;
            wleft_reg   <= wleft_next;
            granted_reg <= granted_next;
        end
    end

endmodule

>>> hdl/brbq_cmd_queue.sv
// ----------------------------------------------------------------------------
// brbq_cmd_queue
// Short command queue between front end and back end.
// ----------------------------------------------------------------------------
module brbq_cmd_queue
    import brbq_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t push_cmd,
    input  logic pop,
    output logic full,
    output logic not_empty,
    output cmd_t head
);

    localparam int QA_W = $clog2(CMDQ_DEPTH);
    localparam int QC_W = $clog2(CMDQ_DEPTH + 1);

    cmd_t            slot_reg [CMDQ_DEPTH];
    logic [QA_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QC_W-1:0] cnt_reg;

    assign full      = (cnt_reg == QC_W'(CMDQ_DEPTH));
    assign not_empty = (cnt_reg != '0);
    assign head      = slot_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == QA_W'(CMDQ_DEPTH - 1)) ? '0 :
                              wr_ptr_reg + QA_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == QA_W'(CMDQ_DEPTH - 1)) ? '0 :
                              rd_ptr_reg + QA_W'(1);
            end
            if (push && !pop)
            begin
                cnt_reg <= cnt_reg + QC_W'(1);
            end
            else if (pop && !push)
            begin
                cnt_reg <= cnt_reg - QC_W'(1);
            end
        end
    end

endmodule

>>> hdl/brbq_back.sv
// ----------------------------------------------------------------------------
// brbq_back
// Execute commands on the byte store and drive result beats.
// ----------------------------------------------------------------------------
module brbq_back
    import brbq_pkg::*;
#(
    parameter int STORE_DEPTH = STORE_DEPTH_DEF
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic [LEN_W-1:0] act_len,
    input  logic             q_valid,
    input  cmd_t             q_head,
    output logic             pop,
    output logic             done,
    output rsp_t             result
);

    localparam int ADDR_W = $clog2(STORE_DEPTH);

    typedef enum logic [1:0] {
        BK_IDLE = 2'b01,
        BK_READ = 2'b10
    } bk_state_t;

    bk_state_t         state_reg;
    logic              done_reg;
    logic [BYTE_W-1:0] store [STORE_DEPTH];
    logic [BYTE_W-1:0] mem_q_reg;
    logic [LEN_W-1:0]  rd_addr_reg;
    logic [LEN_W-1:0]  left_reg;
    cmd_t              cur_reg;
    rsp_t              out_reg;
    logic              byte_sel_reg;
    logic [LEN_W:0]    addr_inc;
    logic              head_write;

    assign pop        = (state_reg == BK_IDLE) && q_valid;
    assign head_write = pop && !q_head.is_read && q_head.wr_en;
    assign addr_inc   = {1'b0, rd_addr_reg} + (LEN_W+1)'(1);
    assign done       = done_reg;

    always_comb
    begin
        result           = out_reg;
        result.read_byte = byte_sel_reg ? mem_q_reg : '0;
    end

    // byte store: one write or one read per cycle, read data registered
    always_ff @(posedge clk)
    begin
        if (head_write)
        begin
            store[ADDR_W'(q_head.addr)] <= q_head.data;
        end
        if (state_reg == BK_READ)
        begin
            mem_q_reg <= store[ADDR_W'(rd_addr_reg)];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= BK_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            case (state_reg)
                BK_IDLE:
                begin
                    done_reg <= pop && !q_head.is_read;
                    if (pop && q_head.is_read)
                    begin
                        state_reg <= BK_READ;
                    end
                end
                BK_READ:
                begin
                    done_reg <= 1'b1;
                    if (left_reg == LEN_W'(1))
                    begin
                        state_reg <= BK_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= BK_IDLE;
                    done_reg  <= 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            cur_reg     <= q_head;
            rd_addr_reg <= q_head.addr;
            left_reg    <= q_head.count;
            if (!q_head.is_read)
            begin
                byte_sel_reg           <= 1'b0;
                out_reg.read_byte      <= '0;
                out_reg.status         <= q_head.status;
                out_reg.transfer_count <= q_head.count;
                out_reg.used_bytes     <= q_head.used;
                out_reg.is_empty       <= q_head.is_empty;
                out_reg.is_full        <= q_head.is_full;
                out_reg.last           <= 1'b1;
            end
        end
        else if (state_reg == BK_READ)
        begin
            rd_addr_reg <= (addr_inc >= {1'b0, act_len}) ? '0 : addr_inc[LEN_W-1:0];
            left_reg    <= left_reg - LEN_W'(1);
            byte_sel_reg           <= 1'b1;
            out_reg.read_byte      <= '0;
            out_reg.status         <= cur_reg.status;
            out_reg.transfer_count <= cur_reg.count;
            out_reg.used_bytes     <= cur_reg.used;
            out_reg.is_empty       <= cur_reg.is_empty;
            out_reg.is_full        <= cur_reg.is_full;
            out_reg.last           <= (left_reg == LEN_W'(1));
        end
    end

endmodule

>>> hdl/byte_ring_buffer_queue_unit.sv
// ----------------------------------------------------------------------------
// byte_ring_buffer_queue_unit
// Circular byte queue with write transfers, capped reads, clear and query.
// ----------------------------------------------------------------------------
//
//  channel    ports                      handshake
//  ---------  -------------------------  ----------------------------------
//  request    start, busy, request       beat taken when start && !busy
//  result     done, result               one-cycle strobe, never stalled
//  config     cfg_wr_en, cfg_wr_data     written on any edge with cfg_wr_en
//
//  Write, clear and query beats are taken one per cycle while busy is low;
//  each gives its result through the command queue and the registered
//  result beat. A read of n bytes holds the back end for its pop and then
//  n result beats, one per cycle, from the single-port byte store, so busy
//  rises once the four-entry command queue fills behind it. Reset empties
//  the queue and sets the length to 1024; the byte store itself is not
//  cleared and needs no clearing pass. The receiver cannot stall: every
//  done cycle is a delivered beat.
module byte_ring_buffer_queue_unit
    import brbq_pkg::*;
#(
    parameter int STORE_DEPTH = STORE_DEPTH_DEF
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  req_t             request,
    output logic             done,
    output rsp_t             result,
    input  logic             cfg_wr_en,
    input  logic [LEN_W-1:0] cfg_wr_data
);

    // front end to queue
    logic             push;
    cmd_t             push_cmd;
    logic             q_full;
    logic [LEN_W-1:0] act_len;

    // queue to back end
    logic             q_valid;
    cmd_t             q_head;
    logic             pop;

    // Classify each beat and advance pointers and the used count at once,
    // so the next beat sees the updated queue state.
    brbq_front #(
        .STORE_DEPTH (STORE_DEPTH)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .request     (request),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .q_full      (q_full),
        .busy        (busy),
        .push        (push),
        .push_cmd    (push_cmd),
        .act_len     (act_len)
    );

    // Hold classified commands until the back end is free.
    brbq_cmd_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_cmd  (push_cmd),
        .pop       (pop),
        .full      (q_full),
        .not_empty (q_valid),
        .head      (q_head)
    );

    // Write bytes into the store in order and stream read bytes out;
    // order in the queue keeps reads behind the writes that fed them.
    brbq_back #(
        .STORE_DEPTH (STORE_DEPTH)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .act_len (act_len),
        .q_valid (q_valid),
        .q_head  (q_head),
        .pop     (pop),
        .done    (done),
        .result  (result)
    );

endmodule

>>> hdl/brbq_checker.sv
// ----------------------------------------------------------------------------
// brbq_checker
// Port-level checks on result beats of the byte queue.
// ----------------------------------------------------------------------------
module brbq_checker
    import brbq_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input logic done,
    input rsp_t result
);

    // empty flag tracks the used count
    a_empty_flag: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (result.is_empty == (result.used_bytes == '0)))
        else $error("is_empty disagrees with used_bytes");

    // an empty read grants nothing and reports an empty queue
    a_empty_read: assert property (@(posedge clk) disable iff (!rst_n)
        done && (result.status == ST_EMPTY) |->
            (result.transfer_count == '0) && result.is_empty && result.last)
        else $error("empty-read beat malformed");

    // a nonzero data byte only comes with a good status
    a_byte_status: assert property (@(posedge clk) disable iff (!rst_n)
        done && (result.read_byte != '0) |-> (result.status == ST_OK))
        else $error("data byte on a failed beat");

    // read beats of one request stream without gaps
    a_burst: assert property (@(posedge clk) disable iff (!rst_n)
        done && !result.last |=> done)
        else $error("gap inside a read burst");

    // an invalid write grants nothing
    a_invalid: assert property (@(posedge clk) disable iff (!rst_n)
        done && (result.status == ST_INVALID) |->
            (result.transfer_count == '0) && result.last)
        else $error("invalid beat with a grant");

endmodule

bind byte_ring_buffer_queue_unit brbq_checker u_brbq_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .done   (done),
    .result (result)
);
